### hw/rtl/conv3_pkg.sv
// conv3_pkg: shared widths, types and register codes for the 3x3 stream
// convolution. No dependencies; the interfaces, top level, MAC and checker import it.
package conv3_pkg;

  localparam int PIXEL_BITS     = 16;
  localparam int COEF_BITS      = 16;
  localparam int KS             = 3;
  localparam int SUM_BITS       = 35;
  localparam int POS_BITS       = 10;
  localparam int SIZE_BITS      = 11;
  localparam int SZ_CMP_BITS    = 13;   // holds any size up to 4096
  localparam int KROW_BITS      = KS * COEF_BITS;
  localparam int CFG_DATA_BITS  = 48;
  localparam int CFG_IDX_BITS   = 3;
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int PROD_BITS      = PIXEL_BITS + COEF_BITS;
  localparam int RSUM_BITS      = PROD_BITS + 2;

  localparam logic [SIZE_BITS-1:0] SIZE_RESET = 11'd1024;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_FRAME_WIDTH   = 3'd0,
    CFG_FRAME_HEIGHT  = 3'd1,
    CFG_KERNEL_TOP    = 3'd2,
    CFG_KERNEL_MIDDLE = 3'd3,
    CFG_KERNEL_BOTTOM = 3'd4
  } cfg_idx_t;

  typedef logic signed [PIXEL_BITS-1:0] pix_t;
  typedef logic signed [COEF_BITS-1:0]  coef_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic signed [RSUM_BITS-1:0]  rsum_t;
  typedef logic signed [SUM_BITS-1:0]   sum_t;

  // window[row][col]: row 0 is two rows up, col 0 is two columns back
  typedef pix_t  win_t   [KS][KS];
  typedef coef_t coefs_t [KS][KS];

  // One output position handed to the MAC pipeline.
  // dr/dc: output sits on the newest row/column of the window.
  typedef struct packed {
    logic                dr;
    logic                dc;
    logic                top_clip;
    logic                left_clip;
    logic                last;
    logic                done;
    logic [POS_BITS-1:0] row;
    logic [POS_BITS-1:0] col;
  } cand_t;

endpackage

### hw/rtl/conv3_pix_if.sv
// conv3_pix_if: valid/ready channel carrying one input pixel word.
// Depends on conv3_pkg.
interface conv3_pix_if import conv3_pkg::*; ();
  logic valid;
  logic ready;
  pix_t pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

### hw/rtl/conv3_res_if.sv
// conv3_res_if: valid/ready channel carrying one filtered result word.
// Depends on conv3_pkg.
interface conv3_res_if import conv3_pkg::*; ();
  logic                valid;
  logic                ready;
  sum_t                filtered;
  logic [POS_BITS-1:0] out_row;
  logic [POS_BITS-1:0] out_column;
  logic                last_in_run;
  logic                frame_done;

  modport source (output valid, output filtered, output out_row, output out_column,
                  output last_in_run, output frame_done, input ready);
  modport sink   (input valid, input filtered, input out_row, input out_column,
                  input last_in_run, input frame_done, output ready);
endinterface

### hw/rtl/conv3x3_zero_padded_stream_unit.sv
// conv3x3_zero_padded_stream_unit: top level of the 3x3 zero-padded stream
// convolution. Depends on conv3_pkg, conv3_pix_if, conv3_res_if, conv3_ram, conv3_mac.
//
// Pixels enter in raster order, one word per clock while in_if.ready is high; each
// pixel releases 0 to 4 results (normally one, two at row ends and in the last row,
// four at the last pixel), and the result port moves one word per clock while
// out_if.ready is high, so a pixel that releases several results holds back the
// input while they are emitted. The window stage, which emits one output position
// per cycle while the MAC accepts, sets that rate. An accepted pixel's first result
// passes line-store read (at acceptance), window, products, row sums, output register.
// Both previous rows sit in one MAX_WIDTH x 32-bit line store
// with a registered read port; it needs no clearing after reset. Output
// (r,c) = sum of pixel(r-1+i, c-1+j) * k(i,j), outside pixels taken as zero,
// and it trails the input by one row and one pixel.
module conv3x3_zero_padded_stream_unit import conv3_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                     clk,
  input  logic                     rst_n,
  conv3_pix_if.sink                in_if,
  conv3_res_if.source              out_if,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  localparam int COL_BITS = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_BITS = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam logic [SZ_CMP_BITS-1:0] MaxW = SZ_CMP_BITS'(MAX_WIDTH);
  localparam logic [SZ_CMP_BITS-1:0] MaxH = SZ_CMP_BITS'(MAX_HEIGHT);

  typedef struct packed {
    logic [3:0]          mask;     // {colB rowB, colB rowA, colA rowB, colA rowA}
    logic                top_a;
    logic                top_b;
    logic                left_a;
    logic                left_b;
    logic [POS_BITS-1:0] row_a;
    logic [POS_BITS-1:0] row_b;
    logic [POS_BITS-1:0] col_a;
    logic [POS_BITS-1:0] col_b;
  } emit_t;

  // configuration
  logic [SIZE_BITS-1:0] fw_r, fh_r;
  logic [KROW_BITS-1:0] kern_r [KS];
  logic [SZ_CMP_BITS-1:0] fw_x, fh_x, w_eff, h_eff;
  logic [COL_BITS-1:0] last_col;
  logic [ROW_BITS-1:0] last_row;
  coefs_t coefs;

  // position counters
  logic [COL_BITS-1:0] col_cnt_r, c_cl;
  logic [ROW_BITS-1:0] row_cnt_r, r_cl;
  logic last_c, last_r, in_acc;
  emit_t emit_new;

  // line-store stage
  logic                  s1_v_r;
  pix_t                  s1_px_r;
  logic [COL_BITS-1:0]   s1_c_r;
  emit_t                 s1_emit_r;
  logic [2*PIXEL_BITS-1:0] ram_rd, byp_r, ups;
  logic                  byp_v_r;
  pix_t                  up_cur, up2_cur;
  logic                  s1_adv;

  // window / emit stage
  win_t   win_r;
  logic   s2_v_r;
  emit_t  s2_emit_r;
  logic [3:0] sel;
  logic [1:0] sel_k;
  cand_t  cand;
  logic   cand_ready, cand_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= SIZE_RESET;
      fh_r <= SIZE_RESET;
      for (int i = 0; i < KS; i++) begin
        kern_r[i] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:   fw_r      <= cfg_wdata[SIZE_BITS-1:0];
        CFG_FRAME_HEIGHT:  fh_r      <= cfg_wdata[SIZE_BITS-1:0];
        CFG_KERNEL_TOP:    kern_r[0] <= cfg_wdata[KROW_BITS-1:0];
        CFG_KERNEL_MIDDLE: kern_r[1] <= cfg_wdata[KROW_BITS-1:0];
        CFG_KERNEL_BOTTOM: kern_r[2] <= cfg_wdata[KROW_BITS-1:0];
        default: ;
      endcase
    end
  end

  // size zero acts as one, oversize saturates
  always_comb begin
    fw_x = SZ_CMP_BITS'(fw_r);
    fh_x = SZ_CMP_BITS'(fh_r);
    if (fw_x == '0) begin
      w_eff = SZ_CMP_BITS'(1);
    end else if (fw_x > MaxW) begin
      w_eff = MaxW;
    end else begin
      w_eff = fw_x;
    end
    if (fh_x == '0) begin
      h_eff = SZ_CMP_BITS'(1);
    end else if (fh_x > MaxH) begin
      h_eff = MaxH;
    end else begin
      h_eff = fh_x;
    end
    last_col = COL_BITS'(w_eff - 1'b1);
    last_row = ROW_BITS'(h_eff - 1'b1);
  end

  always_comb begin
    for (int i = 0; i < KS; i++) begin
      for (int j = 0; j < KS; j++) begin
        coefs[i][j] = kern_r[i][COEF_BITS*j +: COEF_BITS];
      end
    end
  end

  // counters past a shrunken frame are taken as the last column / row
  assign c_cl   = (col_cnt_r > last_col) ? last_col : col_cnt_r;
  assign r_cl   = (row_cnt_r > last_row) ? last_row : row_cnt_r;
  assign last_c = (c_cl == last_col);
  assign last_r = (r_cl == last_row);
  assign in_acc = in_if.valid && in_if.ready;

  always_comb begin
    emit_new.mask[0] = (c_cl != '0) && (r_cl != '0);
    emit_new.mask[1] = (c_cl != '0) && last_r;
    emit_new.mask[2] = last_c && (r_cl != '0);
    emit_new.mask[3] = last_c && last_r;
    emit_new.top_a   = (r_cl == ROW_BITS'(1));
    emit_new.top_b   = (r_cl == '0);
    emit_new.left_a  = (c_cl == COL_BITS'(1));
    emit_new.left_b  = (c_cl == '0);
    emit_new.row_a   = POS_BITS'(r_cl - 1'b1);
    emit_new.row_b   = POS_BITS'(r_cl);
    emit_new.col_a   = POS_BITS'(c_cl - 1'b1);
    emit_new.col_b   = POS_BITS'(c_cl);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (in_acc) begin
      if (last_c) begin
        col_cnt_r <= '0;
        row_cnt_r <= last_r ? '0 : ROW_BITS'(r_cl + 1'b1);
      end else begin
        col_cnt_r <= COL_BITS'(c_cl + 1'b1);
        row_cnt_r <= r_cl;
      end
    end
  end

  // line store: {two rows up, one row up} per column
  conv3_ram #(
    .WIDTH(2 * PIXEL_BITS),
    .DEPTH(MAX_WIDTH)
  ) u_lines (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_c_r),
    .wdata ({up_cur, s1_px_r}),
    .re    (in_acc),
    .raddr (c_cl),
    .rdata (ram_rd)
  );

  // read of the column being written in the same cycle (one-column frames)
  assign ups     = byp_v_r ? byp_r : ram_rd;
  assign up2_cur = ups[2*PIXEL_BITS-1:PIXEL_BITS];
  assign up_cur  = ups[PIXEL_BITS-1:0];

  assign s1_adv      = s1_v_r && (!s2_v_r || (cand_fire && cand.last));
  assign in_if.ready = !s1_v_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      byp_v_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_v_r  <= 1'b1;
        byp_v_r <= s1_adv && (s1_c_r == c_cl);
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_px_r   <= in_if.pixel;
      s1_c_r    <= c_cl;
      s1_emit_r <= emit_new;
      byp_r     <= {up_cur, s1_px_r};
    end
  end

  // window shifts one column per pixel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < KS; i++) begin
        for (int j = 0; j < KS; j++) begin
          win_r[i][j] <= '0;
        end
      end
    end else if (s1_adv) begin
      for (int i = 0; i < KS; i++) begin
        win_r[i][0] <= win_r[i][1];
        win_r[i][1] <= win_r[i][2];
      end
      win_r[0][2] <= up2_cur;
      win_r[1][2] <= up_cur;
      win_r[2][2] <= s1_px_r;
    end
  end

  // emit positions lowest mask bit first: column-major, then row
  always_comb begin
    if (s2_emit_r.mask[0]) begin
      sel = 4'b0001; sel_k = 2'd0;
    end else if (s2_emit_r.mask[1]) begin
      sel = 4'b0010; sel_k = 2'd1;
    end else if (s2_emit_r.mask[2]) begin
      sel = 4'b0100; sel_k = 2'd2;
    end else begin
      sel = 4'b1000; sel_k = 2'd3;
    end
    cand.dr        = sel_k[0];
    cand.dc        = sel_k[1];
    cand.top_clip  = sel_k[0] ? s2_emit_r.top_b : s2_emit_r.top_a;
    cand.left_clip = sel_k[1] ? s2_emit_r.left_b : s2_emit_r.left_a;
    cand.row       = sel_k[0] ? s2_emit_r.row_b : s2_emit_r.row_a;
    cand.col       = sel_k[1] ? s2_emit_r.col_b : s2_emit_r.col_a;
    cand.last      = (s2_emit_r.mask & ~sel) == 4'b0000;
    cand.done      = sel_k[0] && sel_k[1];
  end

  assign cand_fire = s2_v_r && cand_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s1_adv) begin
      s2_v_r <= |s1_emit_r.mask;
    end else if (cand_fire && cand.last) begin
      s2_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_emit_r <= s1_emit_r;
    end else if (cand_fire) begin
      s2_emit_r.mask <= s2_emit_r.mask & ~sel;
    end
  end

  conv3_mac u_mac (
    .clk        (clk),
    .rst_n      (rst_n),
    .cand_valid (s2_v_r),
    .cand_ready (cand_ready),
    .cand       (cand),
    .win        (win_r),
    .coefs      (coefs),
    .out_if     (out_if)
  );

endmodule

### hw/rtl/conv3_ram.sv
// conv3_ram: generic simple dual-port RAM, one write and one read port,
// registered read data (old data on same-address read/write). No dependencies.
module conv3_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/conv3_mac.sv
// conv3_mac: 3x3 multiply-accumulate pipeline (operand select + products,
// row sums, final sum in the output register). Depends on conv3_pkg, conv3_res_if.
module conv3_mac import conv3_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cand_valid,
  output logic               cand_ready,
  input  cand_t              cand,
  input  win_t               win,
  input  coefs_t             coefs,
  conv3_res_if.source        out_if
);

  pix_t  opnd [KS][KS];
  prod_t prod_r [KS][KS];
  rsum_t rsum_r [KS];
  sum_t  sum_r;
  cand_t p_tag_r, q_tag_r, o_tag_r;
  logic  p_v_r, q_v_r, o_v_r;
  logic  adv_p, adv_q, adv_o;

  // Pick the window tap that lines up with coefficient (i,j) for this output;
  // taps past the window edge or outside the frame read as zero.
  for (genvar gi = 0; gi < KS; gi++) begin : g_row
    for (genvar gj = 0; gj < KS; gj++) begin : g_col
      pix_t v00, v01, v10, v11;
      logic ok;

      assign v00 = win[gi][gj];
      if (gj < KS - 1) begin : g_v01
        assign v01 = win[gi][gj+1];
      end else begin : g_z01
        assign v01 = '0;
      end
      if (gi < KS - 1) begin : g_v10
        assign v10 = win[gi+1][gj];
      end else begin : g_z10
        assign v10 = '0;
      end
      if (gi < KS - 1 && gj < KS - 1) begin : g_v11
        assign v11 = win[gi+1][gj+1];
      end else begin : g_z11
        assign v11 = '0;
      end

      assign ok = !(cand.top_clip && (gi == 0)) && !(cand.left_clip && (gj == 0));

      always_comb begin
        if (!ok) begin
          opnd[gi][gj] = '0;
        end else begin
          case ({cand.dr, cand.dc})
            2'b00:   opnd[gi][gj] = v00;
            2'b01:   opnd[gi][gj] = v01;
            2'b10:   opnd[gi][gj] = v10;
            default: opnd[gi][gj] = v11;
          endcase
        end
      end
    end
  end

  assign adv_o      = !o_v_r || out_if.ready;
  assign adv_q      = !q_v_r || adv_o;
  assign adv_p      = !p_v_r || adv_q;
  assign cand_ready = adv_p;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
      q_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      if (adv_p) begin
        p_v_r <= cand_valid;
      end
      if (adv_q) begin
        q_v_r <= p_v_r;
      end
      if (adv_o) begin
        o_v_r <= q_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_p && cand_valid) begin
      p_tag_r <= cand;
      for (int i = 0; i < KS; i++) begin
        for (int j = 0; j < KS; j++) begin
          prod_r[i][j] <= opnd[i][j] * coefs[i][j];
        end
      end
    end
    if (adv_q && p_v_r) begin
      q_tag_r <= p_tag_r;
      for (int i = 0; i < KS; i++) begin
        rsum_r[i] <= RSUM_BITS'(prod_r[i][0]) + RSUM_BITS'(prod_r[i][1])
                   + RSUM_BITS'(prod_r[i][2]);
      end
    end
    if (adv_o && q_v_r) begin
      o_tag_r <= q_tag_r;
      sum_r   <= SUM_BITS'(rsum_r[0]) + SUM_BITS'(rsum_r[1]) + SUM_BITS'(rsum_r[2]);
    end
  end

  assign out_if.valid       = o_v_r;
  assign out_if.filtered    = sum_r;
  assign out_if.out_row     = o_tag_r.row;
  assign out_if.out_column  = o_tag_r.col;
  assign out_if.last_in_run = o_tag_r.last;
  assign out_if.frame_done  = o_tag_r.done;

endmodule

### hw/rtl/conv3_checker.sv
// conv3_checker: assertions on the result port of the 3x3 stream convolution,
// bound to the top level. Depends on conv3_pkg and conv3x3_zero_padded_stream_unit.
module conv3_checker import conv3_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input sum_t                filtered,
  input logic [POS_BITS-1:0] out_row,
  input logic [POS_BITS-1:0] out_column,
  input logic                last_in_run,
  input logic                frame_done
);

  // pipeline flushes on reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // frame end is always the final word released by its pixel
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && frame_done |-> last_in_run)
    else $error("frame_done without last_in_run");

  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(filtered) && $stable(out_row)
      && $stable(out_column) && $stable(last_in_run) && $stable(frame_done))
    else $error("result word changed while stalled");

endmodule

bind conv3x3_zero_padded_stream_unit conv3_checker u_conv3_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .filtered    (out_if.filtered),
  .out_row     (out_if.out_row),
  .out_column  (out_if.out_column),
  .last_in_run (out_if.last_in_run),
  .frame_done  (out_if.frame_done)
);
